// ===== hdl/olst_pkg.sv =====
// olst_pkg: sizes, codes and cell bus types for the ordered list store
// used by olst_cell and ordered_list_store; depends on nothing else
package olst_pkg;

    // store geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // request and result field widths
    localparam int OP_W     = 4;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int POS2_W   = 6;
    localparam int STAT_W   = 2;
    localparam int SIZE_W   = 7;

    // width that holds any position, index or count for compares
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 4'd0,
        OP_INS_TAIL = 4'd1,
        OP_INS_AT   = 4'd2,
        OP_REM_HEAD = 4'd3,
        OP_REM_TAIL = 4'd4,
        OP_REM_AT   = 4'd5,
        OP_READ     = 4'd6,
        OP_REPLACE  = 4'd7,
        OP_SEARCH   = 4'd8,
        OP_COMPARE  = 4'd9,
        OP_SWAP     = 4'd10,
        OP_CLEAR    = 4'd11
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE
    } t_cell_cmd;

    // update broadcast to every cell
    typedef struct packed {
        t_cell_cmd          cmd;
        logic [CMP_W-1:0]   at_a;
        logic [CMP_W-1:0]   at_b;
        logic [VAL_W-1:0]   val_a;
        logic [VAL_W-1:0]   val_b;
    } t_cell_ctl;

    // lookup broadcast to every cell
    typedef struct packed {
        logic [CMP_W-1:0]   pos_a;
        logic [CMP_W-1:0]   pos_b;
        logic [VAL_W-1:0]   val;
        logic [CMP_W-1:0]   count;
    } t_cell_qry;

    // per-cell lookup answer
    typedef struct packed {
        logic [VAL_W-1:0]   sel_a;
        logic [VAL_W-1:0]   sel_b;
        logic               hit_a;
        logic               eq;
    } t_cell_rsp;

endpackage

// ===== hdl/olst_cell.sv =====
// olst_cell: one storage cell of the list, shifts to or from its neighbors
// depends on olst_pkg
module olst_cell (
    input  logic                          i_clk,
    input  logic [olst_pkg::IDX_W-1:0]    i_index,
    input  olst_pkg::t_cell_ctl           i_ctl,
    input  olst_pkg::t_cell_qry           i_qry,
    input  logic [olst_pkg::VAL_W-1:0]    i_prev,
    input  logic [olst_pkg::VAL_W-1:0]    i_next,
    output logic [olst_pkg::VAL_W-1:0]    o_value,
    output olst_pkg::t_cell_rsp           o_rsp
);

    logic [olst_pkg::VAL_W-1:0] r_value;
    logic [olst_pkg::VAL_W-1:0] n_value;
    logic [olst_pkg::CMP_W-1:0] idx;

    assign idx     = olst_pkg::CMP_W'(i_index);
    assign o_value = r_value;

    // next value from the broadcast update
    always_comb begin
        n_value = r_value;
        case (i_ctl.cmd)
            olst_pkg::CELL_INSERT: begin
                if (idx > i_ctl.at_a) begin
                    n_value = i_prev;
                end else if (idx == i_ctl.at_a) begin
                    n_value = i_ctl.val_a;
                end
            end
            olst_pkg::CELL_REMOVE: begin
                if (idx >= i_ctl.at_a) begin
                    n_value = i_next;
                end
            end
            olst_pkg::CELL_WRITE: begin
                if (idx == i_ctl.at_a) begin
                    n_value = i_ctl.val_a;
                end else if (idx == i_ctl.at_b) begin
                    n_value = i_ctl.val_b;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // stored element
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // lookup answers, masked so the row can be or-reduced
    always_comb begin
        o_rsp.sel_a = (idx == i_qry.pos_a) ? r_value : '0;
        o_rsp.sel_b = (idx == i_qry.pos_b) ? r_value : '0;
        o_rsp.hit_a = (idx == i_qry.pos_a) && (r_value == i_qry.val);
        o_rsp.eq    = (idx < i_qry.count) && (r_value == i_qry.val);
    end

endmodule

// ===== hdl/ordered_list_store.sv =====
// ordered_list_store: list engine over a row of olst_cell shift cells
// depends on olst_pkg and olst_cell
// result strobe o_valid is high in S_WRITE, the update state after the lookup state S_READ
// that start enters; all cells shift or load in parallel in the update cycle, and a new
// request can be taken in it; busy is high in the lookup cycle over the cell row
// reset: synchronous active-low i_rst_n empties the list and returns to idle
// the result is shown for one cycle only; the receiver cannot stall it
module ordered_list_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [olst_pkg::OP_W-1:0]      i_op,
    input  logic signed [olst_pkg::VAL_W-1:0] i_value,
    input  logic [olst_pkg::POS_W-1:0]     i_position,
    input  logic [olst_pkg::POS2_W-1:0]    i_other_position,
    output logic                           o_valid,
    output logic [olst_pkg::STAT_W-1:0]    o_status,
    output logic signed [olst_pkg::VAL_W-1:0] o_data,
    output logic                           o_found,
    output logic [olst_pkg::SIZE_W-1:0]    o_size,
    output logic                           o_is_empty
);

    localparam int NCELL = olst_pkg::CAPACITY;
    localparam int CMP_W = olst_pkg::CMP_W;
    localparam int VAL_W = olst_pkg::VAL_W;

    olst_pkg::t_state r_state;
    olst_pkg::t_state n_state;

    logic                           load_req;
    logic                           apply;

    // latched request
    logic [olst_pkg::OP_W-1:0]      r_op;
    logic [VAL_W-1:0]               r_value;
    logic [olst_pkg::POS_W-1:0]     r_pos;
    logic [olst_pkg::POS2_W-1:0]    r_pos2;

    // list size
    logic [olst_pkg::CNT_W-1:0]     r_count;
    logic [olst_pkg::CNT_W-1:0]     r_count_next;
    logic [olst_pkg::CNT_W-1:0]     n_count_next;

    // update and result registers, filled in the lookup cycle
    olst_pkg::t_cell_ctl            r_ctl;
    olst_pkg::t_cell_ctl            n_ctl;
    olst_pkg::t_status              r_status;
    olst_pkg::t_status              n_status;
    logic [VAL_W-1:0]               r_data;
    logic [VAL_W-1:0]               n_data;
    logic                           r_found;
    logic                           n_found;

    // cell row wiring
    olst_pkg::t_cell_ctl            cell_ctl;
    olst_pkg::t_cell_qry            cell_qry;
    logic [VAL_W-1:0]               cell_val [NCELL];
    olst_pkg::t_cell_rsp            cell_rsp [NCELL];
    logic [VAL_W-1:0]               rd_a;
    logic [VAL_W-1:0]               rd_b;
    logic                           hit_a;
    logic                           any_eq;

    logic [CMP_W-1:0]               n_cmp;
    logic [CMP_W-1:0]               pos_cmp;
    logic [CMP_W-1:0]               pos2_cmp;
    logic                           full;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            olst_pkg::S_IDLE:  n_state = start ? olst_pkg::S_READ : olst_pkg::S_IDLE;
            olst_pkg::S_READ:  n_state = olst_pkg::S_WRITE;
            olst_pkg::S_WRITE: n_state = start ? olst_pkg::S_READ : olst_pkg::S_IDLE;
            default:           n_state = olst_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy    = 1'b0;
        o_valid = 1'b0;
        apply   = 1'b0;
        case (r_state)
            olst_pkg::S_READ: begin
                busy = 1'b1;
            end
            olst_pkg::S_WRITE: begin
                o_valid = 1'b1;
                apply   = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    assign load_req = start && !busy;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olst_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (apply) begin
                r_count <= r_count_next;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (load_req) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_pos   <= i_position;
            r_pos2  <= i_other_position;
        end
    end

    // lookup broadcast
    assign pos_cmp  = CMP_W'(r_pos);
    assign pos2_cmp = CMP_W'(r_pos2);
    assign n_cmp    = CMP_W'(r_count);
    assign full     = (r_count == olst_pkg::CNT_W'(NCELL));

    always_comb begin
        cell_qry.pos_a = pos_cmp;
        cell_qry.pos_b = pos2_cmp;
        cell_qry.val   = r_value;
        cell_qry.count = n_cmp;
    end

    // update broadcast, only in the update cycle
    always_comb begin
        cell_ctl = r_ctl;
        if (!apply) begin
            cell_ctl.cmd = olst_pkg::CELL_HOLD;
        end
    end

    // row of cells
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic [VAL_W-1:0] prev_val;
        logic [VAL_W-1:0] next_val;
        if (g == 0) begin : g_first
            assign prev_val = '0;
        end else begin : g_inner_p
            assign prev_val = cell_val[g-1];
        end
        if (g == NCELL - 1) begin : g_last
            assign next_val = '0;
        end else begin : g_inner_n
            assign next_val = cell_val[g+1];
        end
        olst_cell u_cell (
            .i_clk   (i_clk),
            .i_index (olst_pkg::IDX_W'(g)),
            .i_ctl   (cell_ctl),
            .i_qry   (cell_qry),
            .i_prev  (prev_val),
            .i_next  (next_val),
            .o_value (cell_val[g]),
            .o_rsp   (cell_rsp[g])
        );
    end

    // or-reduce the masked cell answers
    always_comb begin
        rd_a   = '0;
        rd_b   = '0;
        hit_a  = 1'b0;
        any_eq = 1'b0;
        for (int k = 0; k < NCELL; k++) begin
            rd_a   = rd_a | cell_rsp[k].sel_a;
            rd_b   = rd_b | cell_rsp[k].sel_b;
            hit_a  = hit_a | cell_rsp[k].hit_a;
            any_eq = any_eq | cell_rsp[k].eq;
        end
    end

    // decode the request against the current size
    always_comb begin
        n_status     = olst_pkg::STAT_OK;
        n_data       = '0;
        n_found      = 1'b0;
        n_count_next = r_count;
        n_ctl.cmd    = olst_pkg::CELL_HOLD;
        n_ctl.at_a   = pos_cmp;
        n_ctl.at_b   = pos_cmp;
        n_ctl.val_a  = r_value;
        n_ctl.val_b  = r_value;
        case (olst_pkg::t_op'(r_op))
            olst_pkg::OP_INS_HEAD: begin
                if (full) begin
                    n_status = olst_pkg::STAT_FULL;
                end else begin
                    n_ctl.cmd    = olst_pkg::CELL_INSERT;
                    n_ctl.at_a   = '0;
                    n_count_next = r_count + 1'b1;
                end
            end
            olst_pkg::OP_INS_TAIL: begin
                if (full) begin
                    n_status = olst_pkg::STAT_FULL;
                end else begin
                    n_ctl.cmd    = olst_pkg::CELL_INSERT;
                    n_ctl.at_a   = n_cmp;
                    n_count_next = r_count + 1'b1;
                end
            end
            olst_pkg::OP_INS_AT: begin
                if (pos_cmp > n_cmp) begin
                    n_status = olst_pkg::STAT_BADPOS;
                end else if (full) begin
                    n_status = olst_pkg::STAT_FULL;
                end else begin
                    n_ctl.cmd    = olst_pkg::CELL_INSERT;
                    n_count_next = r_count + 1'b1;
                end
            end
            olst_pkg::OP_REM_HEAD: begin
                if (r_count == '0) begin
                    n_status = olst_pkg::STAT_EMPTY;
                end else begin
                    n_ctl.cmd    = olst_pkg::CELL_REMOVE;
                    n_ctl.at_a   = '0;
                    n_count_next = r_count - 1'b1;
                end
            end
            olst_pkg::OP_REM_TAIL: begin
                if (r_count == '0) begin
                    n_status = olst_pkg::STAT_EMPTY;
                end else begin
                    n_ctl.cmd    = olst_pkg::CELL_REMOVE;
                    n_ctl.at_a   = n_cmp - 1'b1;
                    n_count_next = r_count - 1'b1;
                end
            end
            olst_pkg::OP_REM_AT: begin
                if (pos_cmp >= n_cmp) begin
                    n_status = olst_pkg::STAT_BADPOS;
                end else begin
                    n_ctl.cmd    = olst_pkg::CELL_REMOVE;
                    n_count_next = r_count - 1'b1;
                end
            end
            olst_pkg::OP_READ: begin
                if (pos_cmp >= n_cmp) begin
                    n_status = olst_pkg::STAT_BADPOS;
                end else begin
                    n_data = rd_a;
                end
            end
            olst_pkg::OP_REPLACE: begin
                if (pos_cmp >= n_cmp) begin
                    n_status = olst_pkg::STAT_BADPOS;
                end else begin
                    n_ctl.cmd = olst_pkg::CELL_WRITE;
                end
            end
            olst_pkg::OP_SEARCH: begin
                n_found = any_eq;
            end
            olst_pkg::OP_COMPARE: begin
                if (pos_cmp >= n_cmp) begin
                    n_status = olst_pkg::STAT_BADPOS;
                end else begin
                    n_found = hit_a;
                end
            end
            olst_pkg::OP_SWAP: begin
                if (pos_cmp >= n_cmp || pos2_cmp >= n_cmp) begin
                    n_status = olst_pkg::STAT_BADPOS;
                end else begin
                    n_ctl.cmd   = olst_pkg::CELL_WRITE;
                    n_ctl.at_b  = pos2_cmp;
                    n_ctl.val_a = rd_b;
                    n_ctl.val_b = rd_a;
                end
            end
            olst_pkg::OP_CLEAR: begin
                n_count_next = '0;
            end
            default: begin
                n_status = olst_pkg::STAT_OK;
            end
        endcase
    end

    // hold the decoded update and result for the update cycle
    always_ff @(posedge i_clk) begin
        if (r_state == olst_pkg::S_READ) begin
            r_ctl        <= n_ctl;
            r_status     <= n_status;
            r_data       <= n_data;
            r_found      <= n_found;
            r_count_next <= n_count_next;
        end
    end

    // result ports
    assign o_status   = r_status;
    assign o_data     = r_data;
    assign o_found    = r_found;
    assign o_size     = olst_pkg::SIZE_W'(r_count_next);
    assign o_is_empty = (r_count_next == '0);

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("lookup cycle not followed by a result");

    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy raised while a result is shown");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != olst_pkg::STAT_OK) |-> (r_count_next == r_count))
        else $error("failed request changed the size");

    a_size_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_count <= olst_pkg::CNT_W'(NCELL)))
        else $error("size above capacity");

endmodule
